// ===== hdl/psis_pkg.sv =====
// ----------------------------------------------------------------------------
// psis_pkg: shared types for the parity split insertion sorter
// Data width and the link record passed between neighboring sort cells.
// ----------------------------------------------------------------------------
`default_nettype none

package psis_pkg;

  localparam int unsigned DATA_W = 32;

  // What one sort cell shows its neighbors
  typedef struct packed {
    logic              occ;     // cell holds a value
    logic              ahead;   // incoming value sorts before this cell, or the cell is empty
    logic [DATA_W-1:0] val;
  } link_t;

endpackage : psis_pkg

`default_nettype wire

// ===== hdl/psis_sort_cell.sv =====
// ----------------------------------------------------------------------------
// psis_sort_cell: one slot of a shift-register insertion chain
// Keeps, takes the broadcast value, or shifts in from the left on insert;
// shifts in from the right on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module psis_sort_cell #(
  parameter bit DESCEND = 1'b0
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              ins_i,
  input  wire                              pop_i,
  input  wire logic [psis_pkg::DATA_W-1:0] new_val_i,
  input  wire psis_pkg::link_t             left_i,
  input  wire psis_pkg::link_t             right_i,
  output psis_pkg::link_t                  self_o
);

  logic                        occ_q, occ_d;
  logic [psis_pkg::DATA_W-1:0] val_q, val_d;
  logic                        beats;
  logic                        ahead;

  // Compare the broadcast value with the held one
  always_comb begin
    if (DESCEND) begin
      beats = $signed(new_val_i) > $signed(val_q);
    end else begin
      beats = $signed(new_val_i) < $signed(val_q);
    end
    ahead = !occ_q || beats;
  end

  // Choose the next content of the slot
  always_comb begin
    occ_d = occ_q;
    val_d = val_q;
    if (ins_i && ahead) begin
      if (left_i.ahead) begin
        occ_d = left_i.occ;
        val_d = left_i.val;
      end else begin
        occ_d = 1'b1;
        val_d = new_val_i;
      end
    end else if (pop_i) begin
      occ_d = right_i.occ;
      val_d = right_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign self_o = '{occ: occ_q, ahead: ahead, val: val_q};

endmodule : psis_sort_cell

`default_nettype wire

// ===== hdl/psis_chain.sv =====
// ----------------------------------------------------------------------------
// psis_chain: row of sort cells forming one sorted list
// Inserts one value per cycle in order; pops the head toward cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module psis_chain #(
  parameter int unsigned MAX_ITEMS = 64,
  parameter bit          DESCEND   = 1'b0
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              ins_i,
  input  wire                              pop_i,
  input  wire logic [psis_pkg::DATA_W-1:0] new_val_i,
  output psis_pkg::link_t                  head_o
);

  psis_pkg::link_t links [MAX_ITEMS];

  // Build the row of cells, tied off at both ends
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    psis_pkg::link_t left_l;
    psis_pkg::link_t right_l;

    if (i == 0) begin : g_first
      assign left_l = '{occ: 1'b0, ahead: 1'b0, val: '0};
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign right_l = '{occ: 1'b0, ahead: 1'b0, val: '0};
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end

    psis_sort_cell #(
      .DESCEND (DESCEND)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ins_i     (ins_i),
      .pop_i     (pop_i),
      .new_val_i (new_val_i),
      .left_i    (left_l),
      .right_i   (right_l),
      .self_o    (links[i])
    );
  end

  assign head_o = links[0];

endmodule : psis_chain

`default_nettype wire

// ===== hdl/parity_split_insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// parity_split_insertion_sorter: collect a set, emit it parity-sorted
// Even values sorted ascending and odd values sorted descending, each placed
// back at the positions of its own parity in arrival order.
// ----------------------------------------------------------------------------
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  input   | in_valid_i, in_stall_o, value_i,       | in
//          | last_i                                 |
//  output  | out_valid_o, out_stall_i, value_res_o, | out
//          | last_res_o, overflowed_o               |
//
//  Collect: one input beat per cycle; each value is inserted into its chain
//  of cells in the cycle it is accepted, while the sorter has room.
//  Emit: after the last beat, one result per cycle from the chain heads while
//  out_stall_i does not hold them; in_stall_o stays high until the final
//  result is loaded into the output register.
//  Reset clears counts, flags and cell occupancy; no clearing pass.
//  out_stall_i holds the output register and pauses emission.
// ----------------------------------------------------------------------------
`default_nettype none

module parity_split_insertion_sorter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [psis_pkg::DATA_W-1:0] value_i,
  input  wire                              last_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [psis_pkg::DATA_W-1:0]      value_res_o,
  output logic                             last_res_o,
  output logic                             overflowed_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_e;

  state_e                      state_q;
  logic [CW-1:0]               count_q;
  logic [CW-1:0]               remain_q;
  logic                        ovf_q;
  logic                        out_valid_q;
  logic [psis_pkg::DATA_W-1:0] out_val_q;
  logic                        out_last_q;
  logic                        out_ovf_q;
  logic [MAX_ITEMS-1:0]        par_q;

  logic                        in_acc;
  logic                        room;
  logic                        take;
  logic                        odd_sel;
  psis_pkg::link_t             even_head;
  psis_pkg::link_t             odd_head;

  // Handshake and emit decisions
  assign in_stall_o = (state_q == ST_EMIT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = (count_q != CW'(MAX_ITEMS));
  assign take       = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign odd_sel    = par_q[0];

  // Sorted lists
  psis_chain #(
    .MAX_ITEMS (MAX_ITEMS),
    .DESCEND   (1'b0)
  ) u_even (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_i     (in_acc && room && !value_i[0]),
    .pop_i     (take && !odd_sel),
    .new_val_i (value_i),
    .head_o    (even_head)
  );

  psis_chain #(
    .MAX_ITEMS (MAX_ITEMS),
    .DESCEND   (1'b1)
  ) u_odd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_i     (in_acc && room && value_i[0]),
    .pop_i     (take && odd_sel),
    .new_val_i (value_i),
    .head_o    (odd_head)
  );

  // Parity of each position: write at the fill point, shift toward the head
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (in_acc && room && (count_q == CW'(i))) begin
        par_q[i] <= value_i[0];
      end else if (take) begin
        par_q[i] <= (i == MAX_ITEMS - 1) ? 1'b0 : par_q[(i + 1) % MAX_ITEMS];
      end
    end
  end

  // Sequence collect and emit, hold the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      count_q     <= '0;
      remain_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_COLLECT: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_acc) begin
            if (room) begin
              count_q <= count_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_i) begin
              state_q  <= ST_EMIT;
              remain_q <= room ? count_q + CW'(1) : count_q;
            end
          end
        end
        ST_EMIT: begin
          if (take) begin
            out_valid_q <= 1'b1;
            remain_q    <= remain_q - CW'(1);
            if (remain_q == CW'(1)) begin
              state_q <= ST_COLLECT;
              count_q <= '0;
              ovf_q   <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_COLLECT;
        end
      endcase
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_val_q  <= odd_sel ? odd_head.val : even_head.val;
      out_last_q <= (remain_q == CW'(1));
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_res_o  = out_val_q;
  assign last_res_o   = out_last_q;
  assign overflowed_o = out_ovf_q;

endmodule : parity_split_insertion_sorter

`default_nettype wire

// ===== verif/tb_parity_split_insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// tb_parity_split_insertion_sorter: self-checking bench for the sorter
// Feeds sets of signed values through the input channel and predicts each
// emitted set. Positions that held even values get the even values ascending
// and positions that held odd values get the odd values descending, with
// dropping and the overflow flag beyond capacity. Results are checked in order
// against the prediction while both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_parity_split_insertion_sorter;

  localparam int unsigned DW             = psis_pkg::DATA_W;
  localparam int unsigned SET_CAP        = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 40;

  // One input beat, optionally held back until all pending results are out
  typedef struct {
    logic [DW-1:0] value;
    logic          last;
    bit            drain_first;
  } elem_t;

  // One predicted result beat
  typedef struct {
    logic [DW-1:0] value;
    logic          last;
    logic          ovf;
  } sorted_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic [DW-1:0] value_i     = '0;
  logic          last_i      = 1'b0;
  logic          out_stall_i = 1'b0;
  logic          in_stall_o;
  logic          out_valid_o;
  logic [DW-1:0] value_res_o;
  logic          last_res_o;
  logic          overflowed_o;

  parity_split_insertion_sorter #(
    .MAX_ITEMS(SET_CAP)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_res_o (value_res_o),
    .last_res_o  (last_res_o),
    .overflowed_o(overflowed_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  elem_t       feed_q[$];
  sorted_t     sorted_beats[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;
  bit          in_taken       = 1'b0;

  // Shadow of the set being collected
  logic [DW-1:0] even_sorted[$];
  logic [DW-1:0] odd_sorted[$];
  bit            slot_odd[$];
  bit            dropped = 1'b0;

  // Insert one value into its parity list; on the final beat, emit the set
  function automatic void absorb_value(logic [DW-1:0] v, logic fin);
    int      pos;
    int      pe;
    int      po;
    sorted_t r;
    if (slot_odd.size() < SET_CAP) begin
      if (!v[0]) begin
        pos = even_sorted.size();
        while (pos > 0 && $signed(even_sorted[pos-1]) > $signed(v)) pos--;
        even_sorted.insert(pos, v);
      end else begin
        pos = odd_sorted.size();
        while (pos > 0 && $signed(odd_sorted[pos-1]) < $signed(v)) pos--;
        odd_sorted.insert(pos, v);
      end
      slot_odd.push_back(v[0]);
    end else begin
      dropped = 1'b1;
    end
    if (fin) begin
      pe = 0;
      po = 0;
      foreach (slot_odd[i]) begin
        if (slot_odd[i]) begin
          r.value = odd_sorted[po];
          po++;
        end else begin
          r.value = even_sorted[pe];
          pe++;
        end
        r.last = (i == slot_odd.size() - 1);
        r.ovf  = dropped;
        sorted_beats.push_back(r);
      end
      even_sorted.delete();
      odd_sorted.delete();
      slot_odd.delete();
      dropped = 1'b0;
    end
  endfunction

  // Mix of full-range values, small values with repeats, and the extremes
  function automatic logic [DW-1:0] pick_value();
    logic [DW-1:0] corner[7];
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
               32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE};
    case ($urandom_range(9))
      4, 5, 6: return DW'($signed($urandom_range(16)) - 8);
      7:       return corner[$urandom_range(6)];
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_elem(logic [DW-1:0] v, logic fin, bit drain);
    elem_t e;
    e.value       = v;
    e.last        = fin;
    e.drain_first = drain;
    feed_q.push_back(e);
  endtask

  task automatic queue_set(int unsigned n, bit drain);
    for (int unsigned k = 0; k < n; k++) begin
      queue_elem(pick_value(), k == n - 1, drain && k == 0);
    end
  endtask

  // Fill one random phase: mostly short sets, now and then one near capacity
  task automatic queue_phase(int unsigned budget);
    int unsigned pushed;
    int unsigned n;
    pushed = 0;
    queue_set(3, 1'b1);
    while (pushed < budget) begin
      if ($urandom_range(24) == 0) n = $urandom_range(70, 60);
      else n = $urandom_range(10, 1);
      queue_set(n, 1'b0);
      pushed += n;
    end
  endtask

  // Driver: advance to the next beat once the current one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (feed_q.size() > 0 && !(feed_q[0].drain_first && sorted_beats.size() > 0)
          && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        value_i    <= feed_q[0].value;
        last_i     <= feed_q[0].last;
        void'(feed_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: check result beats, predict from accepted input beats
  always @(posedge clk_i) begin
    sorted_t exp_beat;
    bit      out_fire;
    out_fire = out_valid_o && !out_stall_i;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_fire) begin
        if (sorted_beats.size() == 0) begin
          $error("unexpected result beat: value_res %0d", $signed(value_res_o));
          mismatches++;
        end else begin
          exp_beat = sorted_beats.pop_front();
          if (value_res_o !== exp_beat.value) begin
            $error("value_res mismatch: expected %0d, got %0d",
                   $signed(exp_beat.value), $signed(value_res_o));
            mismatches++;
          end
          if (last_res_o !== exp_beat.last) begin
            $error("last_res mismatch: expected %0b, got %0b", exp_beat.last, last_res_o);
            mismatches++;
          end
          if (overflowed_o !== exp_beat.ovf) begin
            $error("overflowed mismatch: expected %0b, got %0b", exp_beat.ovf, overflowed_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) absorb_value(value_i, last_i);
      // Watchdog: count cycles with no beat moving on either side
      if (out_fire || (in_valid_i && !in_stall_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("parity_split_insertion_sorter regression: fail");
          $finish;
        end
      end
    end
  end

  // Stimulus
  initial begin
    // Single even, single odd
    queue_elem(32'd0, 1'b1, 1'b0);
    queue_elem(32'hFFFF_FFFF, 1'b1, 1'b0);
    // Mixed parities with extremes and a repeated value
    queue_elem(32'h7FFF_FFFF, 1'b0, 1'b0);
    queue_elem(32'h8000_0000, 1'b0, 1'b0);
    queue_elem(32'd1, 1'b0, 1'b0);
    queue_elem(32'd0, 1'b0, 1'b0);
    queue_elem(32'hFFFF_FFFE, 1'b0, 1'b0);
    queue_elem(32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_elem(32'd6, 1'b0, 1'b0);
    queue_elem(32'd3, 1'b0, 1'b0);
    queue_elem(32'd6, 1'b1, 1'b0);
    // All even in falling order, then all odd in rising order
    queue_elem(32'd8, 1'b0, 1'b0);
    queue_elem(32'd4, 1'b0, 1'b0);
    queue_elem(32'd2, 1'b1, 1'b0);
    queue_elem(32'hFFFF_FFFD, 1'b0, 1'b0);
    queue_elem(32'd5, 1'b0, 1'b0);
    queue_elem(32'd7, 1'b1, 1'b0);

    // Hold reset, then release it
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full set exactly at capacity, then sets past capacity and a short random phase
    while (feed_q.size() != 0) @(negedge clk_i);
    queue_set(SET_CAP, 1'b1);
    queue_set(SET_CAP + 1, 1'b0);
    queue_set(SET_CAP + 4, 1'b0);
    queue_phase(10);

    while (feed_q.size() != 0) @(negedge clk_i);
    send_idle_pct = 62;
    queue_phase(25);

    while (feed_q.size() != 0) @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    queue_phase(25);

    while (feed_q.size() != 0) @(negedge clk_i);
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    queue_phase(25);

    // Drain, then watch for stray beats
    while (feed_q.size() != 0 || in_valid_i || sorted_beats.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("parity_split_insertion_sorter regression: pass");
    end else begin
      $display("parity_split_insertion_sorter regression: fail");
    end
    $finish;
  end

endmodule
